// File: hw/rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg: PNG scanline unfilter shared definitions
// Beat layouts, register indexes, filter codes and sizing constants.
// ----------------------------------------------------------------------------
package psu_pkg;

    // sizing
    localparam int MAX_ROW_BYTES_DEF = 16384;
    localparam int BYTE_W            = 8;
    localparam int ROW_BYTES_W       = 15;
    localparam int BPP_W             = 3;
    localparam int WIN_W             = 32;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'd1;

    // register reset values
    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 15'd1;
    localparam logic [BPP_W-1:0]       BPP_RST       = 3'd1;

    // largest legal filter code
    localparam logic [BYTE_W-1:0] FILTER_MAX = 8'd4;

    // filter type codes
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // input beat
    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              image_start;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
        logic              row_end;
        logic              bad_filter;
    } out_beat_t;

    // configuration write beat
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } cfg_beat_t;

endpackage

// File: hw/rtl/psu_ifs.sv
// ----------------------------------------------------------------------------
// psu_ifs: PNG scanline unfilter channel interfaces
// Valid/ready channels for input bytes, result bytes and register writes.
// ----------------------------------------------------------------------------

// filtered byte stream
interface psu_in_if;
    import psu_pkg::*;
    logic     valid;
    logic     ready;
    in_beat_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// reconstructed byte stream
interface psu_out_if;
    import psu_pkg::*;
    logic      valid;
    logic      ready;
    out_beat_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// register write channel
interface psu_cfg_if;
    import psu_pkg::*;
    logic      valid;
    logic      ready;
    cfg_beat_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter: PNG filter reconstruction
// Rebuilds inflated-stream scanline bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat fields                         handshake
//  pix_in    in   byte_value[7:0], image_start        valid/ready
//  pix_out   out  pixel_byte[7:0], row_end, bad_filter valid/ready
//  cfg       in   reg_index[0:0], wr_data[14:0]       valid/ready (ready tied high)
//
//  One byte per cycle sustained while the output is not stalled; a byte
//  waits in the input register and its result is loaded into the output
//  register. The rate is set by the single read port of the line store,
//  read one byte ahead from the position register.
//  Reset clears control state; the line store has no reset and its data is
//  ignored on the first row of an image.
//  A stalled output holds its beat; bytes that give no result pass regardless.
//
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    psu_in_if.sink    pix_in,
    psu_out_if.source pix_out,
    psu_cfg_if.sink   cfg
);
    import psu_pkg::*;

    localparam int IDX_W = $clog2(MAX_ROW_BYTES);
    localparam int POS_W = $clog2(MAX_ROW_BYTES + 1);

    // configuration registers
    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [BPP_W-1:0]       bpp_reg;

    // input register
    logic     in_valid_reg;
    in_beat_t in_data_reg;

    // output register
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    out_beat_t out_next;

    // scan state
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    filter_t          kind_reg;
    filter_t          kind_next;
    logic [WIN_W-1:0] left_reg;
    logic [WIN_W-1:0] left_next;
    logic [WIN_W-1:0] upl_reg;
    logic [WIN_W-1:0] upl_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic             stuck_reg;
    logic             stuck_next;

    // datapath
    logic              start;
    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  pos_dec;
    logic [POS_W-1:0]  rd_pos;
    logic              first_eff;
    logic              stuck_eff;
    logic              produce;
    logic              out_free;
    logic              fire;
    logic              out_load;
    logic              last_byte;
    logic [POS_W-1:0]  rb_eff;
    logic [1:0]        dist_sel;
    logic [BYTE_W-1:0] a_byte;
    logic [BYTE_W-1:0] b_byte;
    logic [BYTE_W-1:0] c_byte;
    logic [BYTE_W-1:0] x_byte;
    logic [BYTE_W-1:0] mem_rd;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_idx;
    logic [IDX_W-1:0]  mem_rd_idx;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_BYTES_RST;
            bpp_reg       <= BPP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.reg_index)
                REG_ROW_BYTES: row_bytes_reg <= cfg.payload.wr_data;
                REG_BPP:       bpp_reg       <= cfg.payload.wr_data[BPP_W-1:0];
                default:       ;
            endcase
        end
    end

    // clamped row length and filter distance
    always_comb
    begin
        if (row_bytes_reg == '0)
        begin
            rb_eff = POS_W'(1);
        end
        else if (32'(row_bytes_reg) > 32'(MAX_ROW_BYTES))
        begin
            rb_eff = POS_W'(MAX_ROW_BYTES);
        end
        else
        begin
            rb_eff = POS_W'(row_bytes_reg);
        end
        if (bpp_reg == '0)
        begin
            dist_sel = 2'd0;
        end
        else if (bpp_reg > 3'd4)
        begin
            dist_sel = 2'd3;
        end
        else
        begin
            dist_sel = 2'(bpp_reg - 3'd1);
        end
    end

    // effective state for the byte in the input register
    always_comb
    begin
        start     = in_data_reg.image_start;
        pos_eff   = start ? '0 : pos_reg;
        first_eff = start | first_row_reg;
        stuck_eff = stuck_reg & ~start;
        pos_dec   = pos_eff - POS_W'(1);
        last_byte = (pos_eff >= rb_eff);
        if (stuck_eff)
        begin
            produce = 1'b0;
        end
        else if (pos_eff == '0)
        begin
            produce = (in_data_reg.byte_value > FILTER_MAX);
        end
        else
        begin
            produce = 1'b1;
        end
        out_free = ~out_valid_reg | pix_out.ready;
        fire     = in_valid_reg & (out_free | ~produce);
        out_load = fire & produce;
    end

    // neighbor bytes
    always_comb
    begin
        case (dist_sel)
            2'd0:    a_byte = left_reg[7:0];
            2'd1:    a_byte = left_reg[15:8];
            2'd2:    a_byte = left_reg[23:16];
            2'd3:    a_byte = left_reg[31:24];
            default: a_byte = left_reg[7:0];
        endcase
        case (dist_sel)
            2'd0:    c_byte = upl_reg[7:0];
            2'd1:    c_byte = upl_reg[15:8];
            2'd2:    c_byte = upl_reg[23:16];
            2'd3:    c_byte = upl_reg[31:24];
            default: c_byte = upl_reg[7:0];
        endcase
        b_byte = first_eff ? '0 : mem_rd;
    end

    psu_predict u_predict (
        .kind         (kind_reg),
        .filt_byte    (in_data_reg.byte_value),
        .left_byte    (a_byte),
        .up_byte      (b_byte),
        .up_left_byte (c_byte),
        .recon_byte   (x_byte)
    );

    // next scan state and result
    always_comb
    begin
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        left_next      = left_reg;
        upl_next       = upl_reg;
        first_row_next = first_row_reg;
        stuck_next     = stuck_reg;
        mem_wr_en      = 1'b0;
        out_next       = '0;
        if (fire)
        begin
            if (start)
            begin
                first_row_next = 1'b1;
                stuck_next     = 1'b0;
                pos_next       = '0;
            end
            if (!stuck_eff)
            begin
                if (pos_eff == '0)
                begin
                    if (in_data_reg.byte_value > FILTER_MAX)
                    begin
                        stuck_next          = 1'b1;
                        out_next.bad_filter = 1'b1;
                    end
                    else
                    begin
                        kind_next = filter_t'(in_data_reg.byte_value[2:0]);
                        left_next = '0;
                        upl_next  = '0;
                        pos_next  = POS_W'(1);
                    end
                end
                else
                begin
                    mem_wr_en           = 1'b1;
                    left_next           = {left_reg[WIN_W-BYTE_W-1:0], x_byte};
                    upl_next            = {upl_reg[WIN_W-BYTE_W-1:0], b_byte};
                    out_next.pixel_byte = x_byte;
                    out_next.row_end    = last_byte;
                    if (last_byte)
                    begin
                        pos_next       = '0;
                        first_row_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_eff + POS_W'(1);
                    end
                end
            end
        end
        rd_pos     = (pos_next == '0) ? '0 : (pos_next - POS_W'(1));
        mem_rd_idx = rd_pos[IDX_W-1:0];
        mem_wr_idx = pos_dec[IDX_W-1:0];
    end

    // line store, read one position ahead
    psu_line_mem #(
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (x_byte),
        .rd_idx  (mem_rd_idx),
        .rd_data (mem_rd)
    );

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            kind_reg      <= FILT_NONE;
            left_reg      <= '0;
            upl_reg       <= '0;
            first_row_reg <= 1'b1;
            stuck_reg     <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            left_reg      <= left_next;
            upl_reg       <= upl_next;
            first_row_reg <= first_row_next;
            stuck_reg     <= stuck_next;
        end
    end

    // input register
    assign pix_in.ready = ~in_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pix_in.ready)
        begin
            in_valid_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_in.ready && pix_in.valid)
        begin
            in_data_reg <= pix_in.payload;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_next;
        end
    end

    assign pix_out.valid   = out_valid_reg;
    assign pix_out.payload = out_data_reg;

    // position never runs past the line store
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_ROW_BYTES))
        else $error("scan position beyond line store");

    // an error beat locks the stream
    a_bad_locks: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_next.bad_filter |=> stuck_reg)
        else $error("bad filter did not set error lock");

    // no results while locked, unless a new image starts
    a_stuck_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        stuck_reg && !(in_valid_reg && in_data_reg.image_start) |-> !out_load)
        else $error("result produced while error lock set");

    // row end returns to the filter byte
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_next.row_end |=> pos_reg == '0)
        else $error("row end did not return to filter byte");

endmodule

// File: hw/rtl/psu_line_mem.sv
// ----------------------------------------------------------------------------
// psu_line_mem: previous scanline store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psu_line_mem #(
    parameter int DEPTH = psu_pkg::MAX_ROW_BYTES_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_idx,
    input  logic [psu_pkg::BYTE_W-1:0] wr_data,
    input  logic [IDX_W-1:0]          rd_idx,
    output logic [psu_pkg::BYTE_W-1:0] rd_data
);
    import psu_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // read port, refreshed every cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/psu_predict.sv
// ----------------------------------------------------------------------------
// psu_predict: filter predictor and byte reconstruction
// Forms the None/Sub/Up/Average/Paeth prediction and adds it to the byte.
// ----------------------------------------------------------------------------
module psu_predict (
    input  psu_pkg::filter_t           kind,
    input  logic [psu_pkg::BYTE_W-1:0] filt_byte,
    input  logic [psu_pkg::BYTE_W-1:0] left_byte,
    input  logic [psu_pkg::BYTE_W-1:0] up_byte,
    input  logic [psu_pkg::BYTE_W-1:0] up_left_byte,
    output logic [psu_pkg::BYTE_W-1:0] recon_byte
);
    import psu_pkg::*;

    logic signed [9:0] d_a;
    logic signed [9:0] d_b;
    logic signed [9:0] d_c;
    logic [9:0]        p_a;
    logic [9:0]        p_b;
    logic [9:0]        p_c;
    logic [8:0]        avg_sum;
    logic [BYTE_W-1:0] paeth_pick;
    logic [BYTE_W-1:0] pred;

    // paeth distances: |b-c|, |a-c|, |a+b-2c|
    always_comb
    begin
        d_a = $signed({2'b00, up_byte}) - $signed({2'b00, up_left_byte});
        d_b = $signed({2'b00, left_byte}) - $signed({2'b00, up_left_byte});
        d_c = d_a + d_b;
        p_a = d_a[9] ? 10'(-d_a) : 10'(d_a);
        p_b = d_b[9] ? 10'(-d_b) : 10'(d_b);
        p_c = d_c[9] ? 10'(-d_c) : 10'(d_c);
        if ((p_a <= p_b) && (p_a <= p_c))
        begin
            paeth_pick = left_byte;
        end
        else if (p_b <= p_c)
        begin
            paeth_pick = up_byte;
        end
        else
        begin
            paeth_pick = up_left_byte;
        end
    end

    // prediction select and reconstruction
    always_comb
    begin
        avg_sum = {1'b0, left_byte} + {1'b0, up_byte};
        case (kind)
            FILT_SUB:   pred = left_byte;
            FILT_UP:    pred = up_byte;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth_pick;
            default:    pred = '0;
        endcase
        recon_byte = filt_byte + pred;
    end

endmodule
